### hw/rtl/odp_pkg.sv
// Shared types and constants of the threshold or ordered-dither dot packer.
package odp_pkg;

    // Payload widths fixed by the beat formats.
    localparam int START_X_W    = 16;
    localparam int BLACK_W      = 8;
    localparam int REPEAT_W     = 6;
    localparam int BYTE_INDEX_W = 13;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 64;

    // Default build parameters.
    localparam int DEF_MAX_REPEAT = 32;
    localparam int DEF_X_BITS     = 16;

    // Repeat counts are never taken above this, so one pixel yields at most five bytes.
    localparam int REPEAT_LIMIT = 32;

    // Threshold mode compares against the inverted threshold.
    localparam logic [3:0] THRESH_INVERT = 4'hF;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DITHER_LOW  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DITHER_HIGH = 2'd2;

    // Dot mask for each column of a byte, leftmost pixel in the MSB.
    localparam logic [7:0] BIT_OF_COLUMN [8] = '{
        8'd128, 8'd64, 8'd32, 8'd16, 8'd8, 8'd4, 8'd2, 8'd1
    };

    // Configuration seen by the dot decision unit.
    typedef struct packed {
        logic [3:0]            threshold;
        logic [CFG_DATA_W-1:0] rows_low;
        logic [CFG_DATA_W-1:0] rows_high;
    } t_dot_cfg;

endpackage

### hw/rtl/odp_in_if.sv
// Source pixel channel of the dot packer.
interface odp_in_if;
    import odp_pkg::*;

    logic                valid;
    logic                ready;
    logic                first_of_row;
    logic [1:0]          row_phase;
    logic [START_X_W-1:0] start_x;
    logic [BLACK_W-1:0]  black;
    logic [REPEAT_W-1:0] repeat_req;
    logic                last_of_row;

    modport source (
        output valid, first_of_row, row_phase, start_x, black, repeat_req, last_of_row,
        input  ready
    );
    modport sink (
        input  valid, first_of_row, row_phase, start_x, black, repeat_req, last_of_row,
        output ready
    );
endinterface

### hw/rtl/odp_out_if.sv
// Packed byte channel of the dot packer.
interface odp_out_if;
    import odp_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [BYTE_INDEX_W-1:0] byte_index;
    logic [7:0]              byte_bits;
    logic                    row_done;

    modport source (
        output valid, byte_index, byte_bits, row_done,
        input  ready
    );
    modport sink (
        input  valid, byte_index, byte_bits, row_done,
        output ready
    );
endinterface

### hw/rtl/odp_cfg_if.sv
// Configuration write channel of the dot packer.
interface odp_cfg_if;
    import odp_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

### hw/rtl/odp_dot_unit.sv
// Shared dot decision unit: picks the limit and compares the pixel intensity against it.
module odp_dot_unit
    import odp_pkg::*;
(
    input  t_dot_cfg           i_cfg,
    input  logic [1:0]         i_row,
    input  logic [1:0]         i_col,
    input  logic [BLACK_W-1:0] i_black,
    output logic               o_dot
);

    logic [CFG_DATA_W-1:0] rows_word;
    logic [2:0]            entry_sel;
    logic [7:0]            matrix_entry;
    logic [7:0]            limit;

    // Rows 0 and 1 live in the low word, rows 2 and 3 in the high word.
    assign rows_word    = i_row[1] ? i_cfg.rows_high : i_cfg.rows_low;
    assign entry_sel    = {i_row[0], i_col};
    assign matrix_entry = rows_word[{entry_sel, 3'b000} +: 8];

    // A nonzero threshold overrides the dither matrix.
    always_comb begin
        if (i_cfg.threshold != 4'd0) begin
            limit = {4'd0, i_cfg.threshold ^ THRESH_INVERT};
        end else begin
            limit = matrix_entry;
        end
    end

    assign o_dot = (i_black > limit);

endmodule

### hw/rtl/odp_seq.sv
// Pixel sequencer: expands each pixel into dots, one per unstalled cycle, packed into bytes.
module odp_seq
    import odp_pkg::*;
#(
    parameter int MAX_REPEAT = DEF_MAX_REPEAT,
    parameter int X_BITS     = DEF_X_BITS
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_dot_cfg i_cfg,
    odp_in_if.sink   i_pix,
    odp_out_if.source o_dot
);

    localparam int REPEAT_CAP = (MAX_REPEAT > REPEAT_LIMIT) ? REPEAT_LIMIT : MAX_REPEAT;
    localparam int CNT_W      = $clog2(REPEAT_CAP + 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_RUN   = 3'b010,
        S_FLUSH = 3'b100
    } t_state;

    t_state                  r_state, n_state;
    logic [X_BITS-1:0]       r_x, n_x;
    logic [7:0]              r_acc, n_acc;
    logic [1:0]              r_row, n_row;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic [BLACK_W-1:0]      r_black, n_black;
    logic                    r_last, n_last;
    logic                    r_out_valid, n_out_valid;
    logic [BYTE_INDEX_W-1:0] r_out_index, n_out_index;
    logic [7:0]              r_out_bits, n_out_bits;
    logic                    r_out_done, n_out_done;

    logic                    dot;
    logic [7:0]              acc_with_dot;
    logic [START_X_W-1:0]    x_wide;
    logic [X_BITS-1:0]       x_next;
    logic                    slot_free;
    logic [REPEAT_W-1:0]     rep_clamped;

    odp_dot_unit u_dot (
        .i_cfg   (i_cfg),
        .i_row   (r_row),
        .i_col   (r_x[1:0]),
        .i_black (r_black),
        .o_dot   (dot)
    );

    assign acc_with_dot = dot ? (r_acc | BIT_OF_COLUMN[r_x[2:0]]) : r_acc;
    assign x_wide       = START_X_W'(r_x);
    assign x_next       = r_x + X_BITS'(1);
    assign slot_free    = !r_out_valid || o_dot.ready;

    // Repeat of zero counts as one; large repeats saturate.
    always_comb begin
        if (i_pix.repeat_req == '0) begin
            rep_clamped = REPEAT_W'(1);
        end else if (i_pix.repeat_req > REPEAT_W'(REPEAT_CAP)) begin
            rep_clamped = REPEAT_W'(REPEAT_CAP);
        end else begin
            rep_clamped = i_pix.repeat_req;
        end
    end

    assign i_pix.ready = (r_state == S_IDLE);

    assign o_dot.valid      = r_out_valid;
    assign o_dot.byte_index = r_out_index;
    assign o_dot.byte_bits  = r_out_bits;
    assign o_dot.row_done   = r_out_done;

    // Next-state logic of the sequencer and the output register.
    always_comb begin
        n_state     = r_state;
        n_x         = r_x;
        n_acc       = r_acc;
        n_row       = r_row;
        n_cnt       = r_cnt;
        n_black     = r_black;
        n_last      = r_last;
        n_out_valid = r_out_valid && !o_dot.ready;
        n_out_index = r_out_index;
        n_out_bits  = r_out_bits;
        n_out_done  = r_out_done;

        unique case (r_state)
            S_IDLE: begin
                if (i_pix.valid) begin
                    n_black = i_pix.black;
                    n_last  = i_pix.last_of_row;
                    n_cnt   = CNT_W'(rep_clamped);
                    if (i_pix.first_of_row) begin
                        n_x   = i_pix.start_x[X_BITS-1:0];
                        n_row = i_pix.row_phase;
                        n_acc = '0;
                    end
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                // A completed byte needs the output register; otherwise hold this dot.
                if (r_x[2:0] != 3'd7 || slot_free) begin
                    if (r_x[2:0] == 3'd7) begin
                        n_out_valid = 1'b1;
                        n_out_index = x_wide[START_X_W-1:3];
                        n_out_bits  = acc_with_dot;
                        n_out_done  = r_last && (r_cnt == CNT_W'(1));
                        n_acc       = '0;
                    end else begin
                        n_acc = acc_with_dot;
                    end
                    n_x   = x_next;
                    n_cnt = r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        if (r_last && x_next[2:0] != 3'd0) begin
                            n_state = S_FLUSH;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            S_FLUSH: begin
                // The partial byte at row end closes the row.
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_index = x_wide[START_X_W-1:3];
                    n_out_bits  = r_acc;
                    n_out_done  = 1'b1;
                    n_acc       = '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and position state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_x         <= '0;
            r_acc       <= '0;
            r_row       <= '0;
            r_cnt       <= '0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_x         <= n_x;
            r_acc       <= n_acc;
            r_row       <= n_row;
            r_cnt       <= n_cnt;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_black     <= n_black;
        r_out_index <= n_out_index;
        r_out_bits  <= n_out_bits;
        r_out_done  <= n_out_done;
    end

endmodule

### hw/rtl/threshold_or_ordered_dither_packer.sv
// Top level of the threshold or ordered-dither dot packer with its configuration registers.
//
// Each source pixel beat is expanded into repeat_req printer dots (zero counts as one,
// values above MAX_REPEAT or 32 saturate), and each dot is decided by one shared compare
// unit, one dot per clock; a stalled output holds the sequencer only when a byte must be
// emitted. The input is not ready while a pixel is expanded or its partial byte flushed.
// A dot is set when black exceeds threshold XOR 15 (threshold nonzero) or the 4x4 dither
// matrix entry at row phase and x mod 4. Dots are packed MSB-first; every completed byte,
// and the partial byte at row end, leaves as one beat with its byte index, to be ORed into
// a cleared line buffer. The last beat of a row carries row_done. Configuration is to be
// written only while idle by the user; the block itself does not enforce this.
module threshold_or_ordered_dither_packer
    import odp_pkg::*;
#(
    parameter int MAX_REPEAT = DEF_MAX_REPEAT,
    parameter int X_BITS     = DEF_X_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    odp_cfg_if.sink   i_cfg,
    odp_in_if.sink    i_pix,
    odp_out_if.source o_dot
);

    t_dot_cfg r_cfg;

    assign i_cfg.ready = 1'b1;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_THRESHOLD:   r_cfg.threshold <= i_cfg.data[3:0];
                REG_DITHER_LOW:  r_cfg.rows_low  <= i_cfg.data;
                REG_DITHER_HIGH: r_cfg.rows_high <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    odp_seq #(
        .MAX_REPEAT (MAX_REPEAT),
        .X_BITS     (X_BITS)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_pix   (i_pix),
        .o_dot   (o_dot)
    );

endmodule

### tb/sv/tb.sv
// Self-checking testbench of the threshold or ordered-dither dot packer.
module tb
    import odp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPEAT_CAP    = (DEF_MAX_REPEAT > REPEAT_LIMIT) ? REPEAT_LIMIT
                                                                    : DEF_MAX_REPEAT;
    localparam int SETTLE_CYCLES = 2 * (REPEAT_LIMIT + 4);
    localparam int STALL_LIMIT   = 2000;
    localparam int SHOWN_ERRORS  = 10;

    // Index past the register list; writes to it must have no effect.
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    // Classic 4x4 Bayer matrix scaled to 0..255, entry 0 in the lowest byte.
    localparam logic [CFG_DATA_W-1:0] BAYER_LOW  = 64'h68E848C8_A8288808;
    localparam logic [CFG_DATA_W-1:0] BAYER_HIGH = 64'h58D878F8_9818B838;

    typedef struct packed {
        logic                 first_of_row;
        logic [1:0]           row_phase;
        logic [START_X_W-1:0] start_x;
        logic [BLACK_W-1:0]   black;
        logic [REPEAT_W-1:0]  repeat_req;
        logic                 last_of_row;
    } t_pixel;

    typedef struct packed {
        logic [BYTE_INDEX_W-1:0] byte_index;
        logic [7:0]              byte_bits;
        logic                    row_done;
    } t_byte_beat;

    // Tracks the packer state and the bytes it still owes.
    class packed_byte_board;
        logic [3:0]            threshold;
        logic [CFG_DATA_W-1:0] rows_low;
        logic [CFG_DATA_W-1:0] rows_high;
        logic [START_X_W-1:0]  x_pos;
        logic [7:0]            acc;
        logic [1:0]            row_sel;
        t_byte_beat            expected_bytes[$];
        int                    errors;

        function new();
            threshold = '0;
            rows_low  = '0;
            rows_high = '0;
            x_pos     = '0;
            acc       = '0;
            row_sel   = '0;
            errors    = 0;
        endfunction

        function void reg_written(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_THRESHOLD:   threshold = data[3:0];
                REG_DITHER_LOW:  rows_low  = data;
                REG_DITHER_HIGH: rows_high = data;
                default: ;
            endcase
        endfunction

        // Level a dot must exceed at printer position x.
        function logic [7:0] dot_limit(logic [START_X_W-1:0] x);
            logic [3:0]            entry;
            logic [CFG_DATA_W-1:0] word;
            entry = {row_sel, x[1:0]};
            word  = entry[3] ? rows_high : rows_low;
            if (threshold != 4'd0)
                return {4'd0, threshold ^ THRESH_INVERT};
            return word[entry[2:0] * 8 +: 8];
        endfunction

        // Expands one accepted pixel beat into the byte beats it must produce.
        function void pixel_taken(t_pixel p);
            int                   reps;
            int                   produced;
            logic [START_X_W-1:0] x;
            produced = 0;
            if (p.first_of_row) begin
                x_pos   = p.start_x;
                row_sel = p.row_phase;
                acc     = '0;
            end
            reps = p.repeat_req;
            if (reps == 0)
                reps = 1;
            if (reps > REPEAT_CAP)
                reps = REPEAT_CAP;
            for (int i = 0; i < reps; i++) begin
                x = x_pos;
                if (p.black > dot_limit(x))
                    acc = acc | BIT_OF_COLUMN[x[2:0]];
                if (x[2:0] == 3'd7) begin
                    expected_bytes.push_back('{byte_index: x[START_X_W-1:3],
                                               byte_bits: acc, row_done: 1'b0});
                    produced++;
                    acc = '0;
                end
                x_pos = x + 1'b1;
            end
            // A row ending on a byte boundary marks its last full byte instead of flushing.
            if (p.last_of_row) begin
                if (x_pos[2:0] != 3'd0)
                    expected_bytes.push_back('{byte_index: x_pos[START_X_W-1:3],
                                               byte_bits: acc, row_done: 1'b1});
                else if (produced > 0)
                    expected_bytes[expected_bytes.size() - 1].row_done = 1'b1;
                acc = '0;
            end
        endfunction

        function void byte_seen(t_byte_beat got);
            t_byte_beat want;
            if (expected_bytes.size() == 0) begin
                errors++;
                if (errors <= SHOWN_ERRORS)
                    $display("mismatch: unexpected beat index=%0h bits=%02h done=%0b",
                             got.byte_index, got.byte_bits, got.row_done);
                return;
            end
            want = expected_bytes.pop_front();
            if (got.byte_index !== want.byte_index || got.byte_bits !== want.byte_bits ||
                got.row_done !== want.row_done) begin
                errors++;
                // Fields are shown as index, bits and row_done.
                if (errors <= SHOWN_ERRORS)
                    $display("mismatch: expected %0h %02h %0b, got %0h %02h %0b",
                             want.byte_index, want.byte_bits, want.row_done,
                             got.byte_index, got.byte_bits, got.row_done);
            end
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    odp_cfg_if cfg_bus ();
    odp_in_if  pix_bus ();
    odp_out_if dot_bus ();

    packed_byte_board board = new();
    int               burst_left = 1;
    int               quiet_cycles = 0;
    int               rx_cycle = 0;

    threshold_or_ordered_dither_packer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_pix   (pix_bus),
        .o_dot   (dot_bus)
    );

    // Free-running clock.
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Receiver: alternates between always ready, random stalls and a fixed stall pattern.
    initial begin
        dot_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rx_cycle++;
            case ((rx_cycle / 97) % 3)
                0:       dot_bus.ready <= 1'b1;
                1:       dot_bus.ready <= ($urandom_range(0, 2) != 0);
                default: dot_bus.ready <= ((rx_cycle % 5) < 2);
            endcase
        end
    end

    // Check every byte beat taken from the output.
    always @(posedge i_clk) begin
        if (i_rst_n && dot_bus.valid && dot_bus.ready)
            board.byte_seen('{byte_index: dot_bus.byte_index, byte_bits: dot_bus.byte_bits,
                              row_done: dot_bus.row_done});
    end

    // Watchdog on cycles with no beat moving on any channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (pix_bus.valid && pix_bus.ready) || (dot_bus.valid && dot_bus.ready) ||
            (cfg_bus.valid && cfg_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic t_pixel pixel(logic first, logic [1:0] phase, logic [15:0] sx,
                                     logic [7:0] black, logic [5:0] rep, logic last);
        return '{first_of_row: first, row_phase: phase, start_x: sx, black: black,
                 repeat_req: rep, last_of_row: last};
    endfunction

    // Mostly small repeats, some up to the cap, a few zero or above the cap.
    function automatic logic [REPEAT_W-1:0] pick_repeat();
        int r;
        r = $urandom_range(0, 19);
        if (r < 13)
            return REPEAT_W'($urandom_range(1, 8));
        if (r < 17)
            return REPEAT_W'($urandom_range(9, REPEAT_CAP));
        if (r == 17)
            return '0;
        return REPEAT_W'($urandom_range(REPEAT_CAP + 1, (1 << REPEAT_W) - 1));
    endfunction

    function automatic t_pixel random_pixel(logic first, logic last);
        t_pixel p;
        p.first_of_row = first;
        p.last_of_row  = last;
        p.row_phase    = 2'($urandom_range(0, 3));
        p.start_x      = ($urandom_range(0, 3) == 0) ? 16'hFFFF - 16'($urandom_range(0, 40))
                                                     : 16'($urandom_range(0, 65535));
        p.black        = ($urandom_range(0, 4) == 0) ? {8{1'($urandom_range(0, 1))}}
                                                     : 8'($urandom_range(0, 255));
        p.repeat_req   = pick_repeat();
        return p;
    endfunction

    // Sends one pixel beat; ends a burst with a random gap.
    task automatic send_pixel(t_pixel p);
        pix_bus.valid        <= 1'b1;
        pix_bus.first_of_row <= p.first_of_row;
        pix_bus.row_phase    <= p.row_phase;
        pix_bus.start_x      <= p.start_x;
        pix_bus.black        <= p.black;
        pix_bus.repeat_req   <= p.repeat_req;
        pix_bus.last_of_row  <= p.last_of_row;
        do @(posedge i_clk); while (pix_bus.ready !== 1'b1);
        board.pixel_taken(p);
        burst_left--;
        if (burst_left <= 0) begin
            pix_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do @(posedge i_clk); while (cfg_bus.ready !== 1'b1);
        cfg_bus.valid <= 1'b0;
        board.reg_written(idx, data);
    endtask

    // Threshold writes carry random upper bits that the block must drop.
    task automatic write_threshold(logic [3:0] level);
        logic [CFG_DATA_W-1:0] data;
        data      = {$urandom, $urandom};
        data[3:0] = level;
        write_reg(REG_THRESHOLD, data);
    endtask

    // Waits until every owed byte has arrived and the block has gone quiet.
    task automatic settle_idle();
        pix_bus.valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Random rows with random content, with some stray beats mixed in.
    task automatic run_rows(int count);
        int sent;
        int len;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 9) < 2) begin
                send_pixel(random_pixel($urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0));
                sent++;
            end else begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                    send_pixel(random_pixel(i == 0, i == len - 1));
                sent += len;
            end
        end
    endtask

    initial begin
        i_rst_n              <= 1'b0;
        cfg_bus.valid        <= 1'b0;
        cfg_bus.index        <= '0;
        cfg_bus.data         <= '0;
        pix_bus.valid        <= 1'b0;
        pix_bus.first_of_row <= 1'b0;
        pix_bus.row_phase    <= '0;
        pix_bus.start_x      <= '0;
        pix_bus.black        <= '0;
        pix_bus.repeat_req   <= 6'd1;
        pix_bus.last_of_row  <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows under the Bayer matrix.
        write_threshold(4'd0);
        write_reg(REG_DITHER_LOW, BAYER_LOW);
        write_reg(REG_DITHER_HIGH, BAYER_HIGH);

        // Repeat extremes: zero, saturated, and a partial byte flushed at row end.
        send_pixel(pixel(1'b1, 2'd0, 16'h0000, 8'd0,   6'd1,  1'b0));
        send_pixel(pixel(1'b0, 2'd0, 16'h0000, 8'd255, 6'd8,  1'b0));
        send_pixel(pixel(1'b0, 2'd0, 16'h0000, 8'd128, 6'd0,  1'b0));
        send_pixel(pixel(1'b0, 2'd0, 16'h0000, 8'd200, 6'd63, 1'b0));
        send_pixel(pixel(1'b0, 2'd0, 16'h0000, 8'd77,  6'd33, 1'b0));
        send_pixel(pixel(1'b0, 2'd3, 16'hFFFF, 8'd255, 6'd32, 1'b0));
        send_pixel(pixel(1'b0, 2'd0, 16'h0000, 8'd100, 6'd3,  1'b1));
        // X wraps past the top, then the row ends exactly on a byte boundary.
        send_pixel(pixel(1'b1, 2'd3, 16'hFFFC, 8'd255, 6'd6,  1'b0));
        send_pixel(pixel(1'b0, 2'd0, 16'h0000, 8'd90,  6'd5,  1'b0));
        send_pixel(pixel(1'b0, 2'd0, 16'h0000, 8'd160, 6'd1,  1'b1));
        // A row left open is dropped by the next row start.
        send_pixel(pixel(1'b1, 2'd1, 16'h1235, 8'd255, 6'd2,  1'b0));
        send_pixel(pixel(1'b1, 2'd2, 16'hAAAA, 8'd30,  6'd4,  1'b0));
        send_pixel(pixel(1'b0, 2'd0, 16'h0000, 8'd255, 6'd4,  1'b1));
        // Pixels after a row end keep going without a row start.
        send_pixel(pixel(1'b0, 2'd0, 16'h0000, 8'd255, 6'd4,  1'b0));
        send_pixel(pixel(1'b0, 2'd0, 16'h0000, 8'd10,  6'd9,  1'b1));
        // Single-pixel rows.
        send_pixel(pixel(1'b1, 2'd2, 16'h5553, 8'd180, 6'd32, 1'b1));
        send_pixel(pixel(1'b1, 2'd1, 16'hFFFF, 8'd255, 6'd1,  1'b1));
        send_pixel(pixel(1'b1, 2'd0, 16'h5555, 8'd255, 6'd2,  1'b1));
        send_pixel(pixel(1'b1, 2'd3, 16'h0008, 8'd0,   6'd8,  1'b1));

        // Threshold mode right at its limit.
        settle_idle();
        write_threshold(4'd8);
        send_pixel(pixel(1'b1, 2'd0, 16'h0100, 8'd7, 6'd4, 1'b0));
        send_pixel(pixel(1'b0, 2'd0, 16'h0000, 8'd8, 6'd4, 1'b1));

        // Random rows over a sweep of settings.
        for (int ph = 0; ph < 6; ph++) begin
            settle_idle();
            case (ph)
                0: begin
                    write_threshold(4'd0);
                    write_reg(REG_DITHER_LOW, '1);
                    write_reg(REG_DITHER_HIGH, '1);
                end
                1: write_threshold(4'd15);
                2: write_threshold(4'd1);
                3: begin
                    write_threshold(4'd0);
                    write_reg(REG_DITHER_LOW, {$urandom, $urandom});
                    write_reg(REG_DITHER_HIGH, {$urandom, $urandom});
                    write_reg(REG_UNUSED, {$urandom, $urandom});
                end
                4: write_threshold(4'($urandom_range(2, 14)));
                default: begin
                    write_threshold(4'd0);
                    write_reg(REG_DITHER_LOW, '0);
                    write_reg(REG_DITHER_HIGH, '0);
                end
            endcase
            run_rows(25);
        end

        settle_idle();
        if (board.errors == 0 && board.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
